### hw/rtl/can_ascii_frame_parser_macros.svh
// Assertion macros shared by the ASCII CAN frame parser RTL.
// Needs no other file; the including module supplies clock, reset and signals.
`ifndef CAN_ASCII_FRAME_PARSER_MACROS_SVH
`define CAN_ASCII_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cafp_pkg.sv
// Package for the ASCII CAN frame parser: character codes, field limits and
// the hex digit decoder. Depends on nothing.
`default_nettype none

package cafp_pkg;

	// Characters that steer the token decoder.
	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_STD_DATA  = 8'h74; // t
	localparam logic [7:0] CHAR_EXT_DATA  = 8'h54; // T
	localparam logic [7:0] CHAR_STD_RTR   = 8'h72; // r
	localparam logic [7:0] CHAR_EXT_RTR   = 8'h52; // R

	// Token layout limits.
	localparam logic [4:0] POS_MAX        = 5'd31;
	localparam logic [3:0] ID_DIGITS_STD  = 4'd3;
	localparam logic [3:0] ID_DIGITS_EXT  = 4'd8;
	localparam logic [4:0] MAX_DLC        = 5'd8;
	localparam logic [4:0] HEX_INVALID    = 5'd16;
	localparam int unsigned PAYLOAD_NIBBLES = 16;

	// Returns the nibble value of a hex digit, or HEX_INVALID for anything else.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_INVALID;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h37);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/can_ascii_frame_parser.sv
// ASCII CAN frame parser: input character register, token decoder and result register.
// Depends on cafp_pkg and can_ascii_frame_parser_macros.svh.
//
// Usage:
// The input channel (in_valid, in_stall, char_in) moves one received character per
// transfer. Tokens end at a carriage return; a well formed t, T, r or R token
// produces one frame transfer on the output channel (out_valid, out_stall and the
// frame fields). Any other token produces nothing.
// A carriage return accepted at the input passes two register stages before its
// frame shows on the output: the input register, then the result register.
// Throughput: one character per cycle unless stalled. The input register and the
// single result register set this; the decoder updates its token state once per cycle.
// The input stalls only when a carriage return waits in the input register while
// an earlier frame still sits stalled in the result register. Other characters keep
// flowing while a frame waits.
// Reset clears the token state to the start of a token and empties both registers.
// A stalled result holds its fields unchanged until taken.
`default_nettype none
`include "can_ascii_frame_parser_macros.svh"

module can_ascii_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      frame_id,
	output logic             is_extended,
	output logic             is_remote,
	output logic [3:0]       data_length,
	output logic [63:0]      payload_bytes
);

	// Input register.
	logic        valid_s1;
	logic [7:0]  char_s1;

	// Token state.
	logic [4:0]  pos_q;
	logic        bad_q;
	logic        ext_q;
	logic        rtr_q;
	logic [31:0] id_q;
	logic [3:0]  len_q;
	logic [63:0] pay_q;

	// Result register.
	logic        out_valid_q;
	logic [31:0] frame_id_q;
	logic        is_extended_q;
	logic        is_remote_q;
	logic [3:0]  data_length_q;
	logic [63:0] payload_bytes_q;

	// Decoder signals.
	logic        s1_is_cr;
	logic        s1_fire;
	logic        in_fire;
	logic        result_ok;
	logic [3:0]  id_digits;
	logic [5:0]  need;
	logic [4:0]  hv;
	logic [4:0]  k;
	logic [4:0]  pos_d;
	logic        bad_d;
	logic        ext_d;
	logic        rtr_d;
	logic [31:0] id_d;
	logic [3:0]  len_d;
	logic [63:0] pay_d;

	// A character leaves the input register unless it is a carriage return
	// that would overwrite a frame still waiting at the output.
	assign s1_is_cr = (char_s1 == cafp_pkg::CHAR_CR);
	assign s1_fire  = valid_s1 && (!s1_is_cr || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_fire;
	assign in_fire  = in_valid && !in_stall;

	// Input register load and drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= char_in;
		end
	end

	// Length of a complete token and whether the current token qualifies.
	assign id_digits = ext_q ? cafp_pkg::ID_DIGITS_EXT : cafp_pkg::ID_DIGITS_STD;
	assign need      = {2'b00, id_digits} + 6'd2 + (rtr_q ? 6'd0 : {1'b0, len_q, 1'b0});
	assign result_ok = !bad_q && ({1'b0, pos_q} >= need);
	assign hv        = cafp_pkg::hex_value(char_s1);
	assign k         = pos_q - 5'(id_digits + 4'd2);

	// Next token state for the character in the input register.
	always_comb begin
		pos_d = pos_q;
		bad_d = bad_q;
		ext_d = ext_q;
		rtr_d = rtr_q;
		id_d  = id_q;
		len_d = len_q;
		pay_d = pay_q;
		if (s1_is_cr) begin
			pos_d = '0;
			bad_d = 1'b0;
			ext_d = 1'b0;
			rtr_d = 1'b0;
			id_d  = '0;
			len_d = '0;
			pay_d = '0;
		end else begin
			if (!bad_q) begin
				if (pos_q == 5'd0) begin
					if (char_s1 == cafp_pkg::CHAR_STD_DATA || char_s1 == cafp_pkg::CHAR_EXT_DATA
							|| char_s1 == cafp_pkg::CHAR_STD_RTR
							|| char_s1 == cafp_pkg::CHAR_EXT_RTR) begin
						ext_d = (char_s1 == cafp_pkg::CHAR_EXT_DATA)
							|| (char_s1 == cafp_pkg::CHAR_EXT_RTR);
						rtr_d = (char_s1 == cafp_pkg::CHAR_STD_RTR)
							|| (char_s1 == cafp_pkg::CHAR_EXT_RTR);
					end else begin
						bad_d = 1'b1;
					end
				end else if ({1'b0, pos_q} <= {2'b00, id_digits}) begin
					if (hv == cafp_pkg::HEX_INVALID) begin
						bad_d = 1'b1;
					end else begin
						id_d = {id_q[27:0], hv[3:0]};
					end
				end else if ({1'b0, pos_q} == {2'b00, id_digits} + 6'd1) begin
					if (hv > cafp_pkg::MAX_DLC) begin
						bad_d = 1'b1;
					end else begin
						len_d = hv[3:0];
					end
				end else if (!rtr_q) begin
					// Payload digit k lands in nibble 15-k, first byte at the top.
					if (k < {len_q, 1'b0} && !k[4]) begin
						if (hv == cafp_pkg::HEX_INVALID) begin
							bad_d = 1'b1;
						end else begin
							for (int i = 0; i < cafp_pkg::PAYLOAD_NIBBLES; i++) begin
								if (k[3:0] == 4'(cafp_pkg::PAYLOAD_NIBBLES - 1 - i)) begin
									pay_d[4*i +: 4] = pay_q[4*i +: 4] | hv[3:0];
								end
							end
						end
					end
				end
			end
			if (pos_q < cafp_pkg::POS_MAX) begin
				pos_d = pos_q + 5'd1;
			end
		end
	end

	// Token state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bad_q <= 1'b0;
			ext_q <= 1'b0;
			rtr_q <= 1'b0;
			id_q  <= '0;
			len_q <= '0;
			pay_q <= '0;
		end else if (s1_fire) begin
			pos_q <= pos_d;
			bad_q <= bad_d;
			ext_q <= ext_d;
			rtr_q <= rtr_d;
			id_q  <= id_d;
			len_q <= len_d;
			pay_q <= pay_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_is_cr && result_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_fire && s1_is_cr && result_ok) begin
			frame_id_q      <= id_q;
			is_extended_q   <= ext_q;
			is_remote_q     <= rtr_q;
			data_length_q   <= len_q;
			payload_bytes_q <= pay_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_id      = frame_id_q;
	assign is_extended   = is_extended_q;
	assign is_remote     = is_remote_q;
	assign data_length   = data_length_q;
	assign payload_bytes = payload_bytes_q;

	// A waiting frame is never overwritten by the next carriage return.
	`CAFP_ASSERT_SAME(a_no_overwrite, clk, arst_n, out_valid_q && out_stall, !(s1_fire && s1_is_cr), "frame overwritten while stalled")

	// A frame appears only after a carriage return left the input register.
	`CAFP_ASSERT_NEXT(a_frame_from_cr, clk, arst_n, !(out_valid_q && out_stall) && !(s1_fire && s1_is_cr), !out_valid_q, "frame without carriage return")

	// Every carriage return restarts the token.
	`CAFP_ASSERT_NEXT(a_cr_restarts, clk, arst_n, s1_fire && s1_is_cr, pos_q == 5'd0 && !bad_q, "token not restarted")

endmodule

`default_nettype wire

### tb/tb_can_ascii_frame_parser.sv
// Self-checking testbench for the ASCII CAN frame parser: directed and random
// character streams, a frame predictor, and a scoreboard on the output channel.
// Depends on cafp_pkg and the can_ascii_frame_parser RTL.

module tb_can_ascii_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	// One decoded CAN frame as it appears on the output channel.
	typedef struct {
		logic [31:0] id;
		logic        ext;
		logic        rtr;
		logic [3:0]  dlc;
		logic [63:0] data;
	} can_frame_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;
	localparam int TOTAL_CHARS  = 550;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] frame_id;
	logic        is_extended;
	logic        is_remote;
	logic [3:0]  data_length;
	logic [63:0] payload_bytes;

	// Characters waiting to be sent, and frames waiting to be received.
	logic [7:0]  char_fifo[$];
	can_frame_t  pending_frames[$];

	// Idle and stall percentages of the current phase.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int error_count = 0;
	int cycle_count = 0;
	int chars_queued = 0;
	int chars_sent = 0;
	int tokens_sent = 0;
	int frames_predicted = 0;
	int frames_checked = 0;
	int ext_checked = 0;
	int rtr_checked = 0;

	// Predictor copy of the token state.
	logic [4:0]  tok_pos = '0;
	logic        tok_rejected = 1'b0;
	logic        tok_ext = 1'b0;
	logic        tok_rtr = 1'b0;
	logic [31:0] tok_id = '0;
	logic [3:0]  tok_dlc = '0;
	logic [63:0] tok_data = '0;

	can_ascii_frame_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_id      (frame_id),
		.is_extended   (is_extended),
		.is_remote     (is_remote),
		.data_length   (data_length),
		.payload_bytes (payload_bytes)
	);

	always #5 clk = ~clk;

	// Nibble value of a hex character, HEX_INVALID for anything else.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] n;
		n = cafp_pkg::HEX_INVALID;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			n = 5'd9 + {2'b00, c[2:0]};
		end
		return n;
	endfunction

	// ASCII hex character for a nibble, in either case.
	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
		if (v < 4'd10) begin
			return 8'h30 + {4'h0, v};
		end
		return (upper ? 8'h37 : 8'h57) + {4'h0, v};
	endfunction

	// Advances the predicted token state by one accepted character; a carriage
	// return closes the token and queues a frame if the token was complete.
	task automatic track_char(input logic [7:0] c);
		logic [4:0] nib;
		int unsigned id_len;
		int unsigned need;
		int unsigned k;
		can_frame_t f;
		id_len = tok_ext ? 8 : 3;
		nib = nibble_of(c);
		if (c == cafp_pkg::CHAR_CR) begin
			need = id_len + 2 + (tok_rtr ? 0 : 2 * tok_dlc);
			if (!tok_rejected && tok_pos >= need) begin
				f.id = tok_id;
				f.ext = tok_ext;
				f.rtr = tok_rtr;
				f.dlc = tok_dlc;
				f.data = tok_data;
				pending_frames.push_back(f);
				frames_predicted++;
			end
			tok_pos = '0;
			tok_rejected = 1'b0;
			tok_ext = 1'b0;
			tok_rtr = 1'b0;
			tok_id = '0;
			tok_dlc = '0;
			tok_data = '0;
		end else begin
			if (!tok_rejected) begin
				if (tok_pos == 0) begin
					if (c == cafp_pkg::CHAR_STD_DATA || c == cafp_pkg::CHAR_EXT_DATA ||
					    c == cafp_pkg::CHAR_STD_RTR || c == cafp_pkg::CHAR_EXT_RTR) begin
						tok_ext = (c == cafp_pkg::CHAR_EXT_DATA || c == cafp_pkg::CHAR_EXT_RTR);
						tok_rtr = (c == cafp_pkg::CHAR_STD_RTR || c == cafp_pkg::CHAR_EXT_RTR);
					end else begin
						tok_rejected = 1'b1;
					end
				end else if (tok_pos <= id_len) begin
					if (nib == cafp_pkg::HEX_INVALID) begin
						tok_rejected = 1'b1;
					end else begin
						tok_id = {tok_id[27:0], nib[3:0]};
					end
				end else if (tok_pos == id_len + 1) begin
					if (nib > cafp_pkg::MAX_DLC) begin
						tok_rejected = 1'b1;
					end else begin
						tok_dlc = nib[3:0];
					end
				end else if (!tok_rtr) begin
					k = tok_pos - (id_len + 2);
					if (k < 2 * tok_dlc) begin
						if (nib == cafp_pkg::HEX_INVALID) begin
							tok_rejected = 1'b1;
						end else begin
							tok_data = tok_data | ({60'h0, nib[3:0]} << (60 - 4 * k));
						end
					end
				end
			end
			if (tok_pos != cafp_pkg::POS_MAX) begin
				tok_pos = tok_pos + 5'd1;
			end
		end
	endtask

	// Compares one received frame with the oldest predicted frame.
	task automatic check_frame();
		can_frame_t want;
		if (pending_frames.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS) begin
				$display("Unexpected frame: id=%h ext=%b rtr=%b len=%0d data=%h",
					frame_id, is_extended, is_remote, data_length, payload_bytes);
			end
		end else begin
			want = pending_frames.pop_front();
			frames_checked++;
			if (is_extended) begin
				ext_checked++;
			end
			if (is_remote) begin
				rtr_checked++;
			end
			if (frame_id !== want.id || is_extended !== want.ext || is_remote !== want.rtr ||
			    data_length !== want.dlc || payload_bytes !== want.data) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("Frame %0d mismatch: expected id=%h ext=%b rtr=%b len=%0d data=%h",
						frames_checked, want.id, want.ext, want.rtr, want.dlc, want.data);
					$display("    got id=%h ext=%b rtr=%b len=%0d data=%h",
						frame_id, is_extended, is_remote, data_length, payload_bytes);
				end
			end
		end
	endtask

	// Driver: presents queued characters, holding each until its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_in <= 8'h00;
		end else begin
			if (in_valid && !in_stall) begin
				track_char(char_in);
				chars_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (char_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					char_in <= char_fifo.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each frame transfer and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_frame();
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d frames outstanding",
				cycle_count, pending_frames.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Queues one token followed by its carriage return.
	task automatic queue_token(input logic [7:0] tok[$]);
		foreach (tok[i]) begin
			char_fifo.push_back(tok[i]);
		end
		char_fifo.push_back(cafp_pkg::CHAR_CR);
		chars_queued += tok.size() + 1;
		tokens_sent++;
	endtask

	task automatic queue_text(input string s);
		logic [7:0] tok[$];
		for (int i = 0; i < s.len(); i++) begin
			tok.push_back(s[i]);
		end
		queue_token(tok);
	endtask

	// Any byte but a carriage return.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		return (b == cafp_pkg::CHAR_CR) ? 8'h8D : b;
	endfunction

	// Builds one random token: mostly well formed frames, some broken frames and
	// some noise. Returns the number of characters that the decoder looks at.
	task automatic queue_random_token(output int body);
		logic [7:0] tok[$];
		logic [7:0] kind;
		logic       upper;
		int         mode;
		int         id_len;
		int         dlc;
		int         fill;
		int         cut;
		mode = $urandom_range(99);
		if (mode < 8) begin
			body = $urandom_range(40);
			for (int i = 0; i < body; i++) begin
				tok.push_back(plain_byte());
			end
		end else begin
			case ($urandom_range(3))
				0: kind = cafp_pkg::CHAR_STD_DATA;
				1: kind = cafp_pkg::CHAR_EXT_DATA;
				2: kind = cafp_pkg::CHAR_STD_RTR;
				default: kind = cafp_pkg::CHAR_EXT_RTR;
			endcase
			id_len = (kind == cafp_pkg::CHAR_EXT_DATA || kind == cafp_pkg::CHAR_EXT_RTR) ? 8 : 3;
			dlc = $urandom_range(8);
			upper = 1'($urandom_range(1));
			fill = $urandom_range(9);
			tok.push_back(kind);
			// Now and then an all-zero or all-ones identifier.
			for (int i = 0; i < id_len; i++) begin
				tok.push_back(hex_char(fill == 0 ? 4'h0 : fill == 1 ? 4'hF :
					4'($urandom_range(15)), 1'($urandom_range(1))));
			end
			tok.push_back(hex_char(4'(dlc), upper));
			if (kind == cafp_pkg::CHAR_STD_DATA || kind == cafp_pkg::CHAR_EXT_DATA) begin
				for (int i = 0; i < 2 * dlc; i++) begin
					tok.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				end
			end
			body = tok.size();
			if ($urandom_range(4) == 0) begin
				fill = $urandom_range(1, 8);
				for (int i = 0; i < fill; i++) begin
					tok.push_back(plain_byte());
				end
			end
			// Broken frames: cut short, a bad character, a length above eight,
			// or an unknown type.
			if (mode >= 78) begin
				case (mode % 4)
					0: begin
						cut = $urandom_range(body - 1);
						while (tok.size() > cut) begin
							void'(tok.pop_back());
						end
					end
					1: tok[$urandom_range(body - 1)] = plain_byte();
					2: tok[id_len + 1] = hex_char(4'($urandom_range(9, 15)), upper);
					default: tok[0] = plain_byte();
				endcase
			end
		end
		queue_token(tok);
	endtask

	// Lets the sender run dry, then waits for every predicted frame.
	task automatic wait_idle();
		int guard;
		@(negedge clk);
		while (char_fifo.size() != 0 || in_valid) begin
			@(negedge clk);
		end
		guard = 0;
		while (pending_frames.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		while (pending_frames.size() != 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS) begin
				$display("Missing frame: id=%h ext=%b rtr=%b len=%0d data=%h",
					pending_frames[0].id, pending_frames[0].ext, pending_frames[0].rtr,
					pending_frames[0].dlc, pending_frames[0].data);
			end
			void'(pending_frames.pop_front());
		end
	endtask

	task automatic set_phase(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	// Stimulus: reset, directed tokens, then random tokens phase by phase.
	initial begin
		int chunk_chars;
		int body;
		int phase;
		phase = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, both frame kinds and each rejection.
		set_phase(0);
		queue_text("");
		queue_text("t1230");
		queue_text("tFFF80123456789abcdef");
		queue_text("T1FFFFFFF8FEDCBA9876543210");
		queue_text("TFFFFFFFF0");
		queue_text("t0000");
		queue_text("r7FF3");
		queue_text("R123456788");
		queue_text("Rfffffff0");
		queue_text("x123");
		queue_text("t12G1");
		queue_text("t1239");
		queue_text("r123A");
		queue_text("t123G");
		queue_text("t1232AB");
		queue_text("t12");
		queue_text("t");
		queue_text("t1231AZ");
		queue_text("t1231ABxyz!");
		queue_text("r1232zz");
		queue_text("T0ABCDEF08aAbBcCdDeEfF0011zzzzzzzzzz");
		queue_text("t-1230");
		queue_text("T 12345670");
		queue_text("tabc1F0");
		wait_idle();

		// Random: each chunk runs under one idle pattern, and the sender holds
		// off between chunks until every predicted frame has arrived.
		while (chars_queued < TOTAL_CHARS) begin
			phase++;
			set_phase(phase);
			chunk_chars = 0;
			@(negedge clk);
			while (chunk_chars < 70) begin
				queue_random_token(body);
				chunk_chars += body;
			end
			wait_idle();
		end

		set_phase(0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d characters in %0d tokens under %0d idle phases.",
			chars_sent, tokens_sent, phase + 1);
		$display("Checked %0d of %0d predicted frames: %0d extended, %0d remote; %0d errors.",
			frames_checked, frames_predicted, ext_checked, rtr_checked, error_count);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
